>>> hw/rtl/rainbow_color_wheel_generator_macros.svh
// Assertion macros shared by the RTL files of the color wheel generator.
`ifndef RAINBOW_COLOR_WHEEL_GENERATOR_MACROS_SVH
`define RAINBOW_COLOR_WHEEL_GENERATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define RCWG_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define RCWG_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RCWG_ASSERT_IMP(lbl, pre, post, msg)
`define RCWG_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

>>> hw/rtl/rcwg_pkg.sv
package rcwg_pkg;

    localparam int PHASE_BITS     = 16;
    localparam int COS_TABLE_BITS = 10;
    localparam int COS_QUARTER    = 1 << (COS_TABLE_BITS - 2);

    localparam int STEP_W = 16;
    localparam int V_W    = 22;
    localparam int NUM_W  = 32;
    localparam int QUO_W  = 8;
    localparam int DEN_W  = V_W + 1;
    localparam int DSH_W  = DEN_W + QUO_W - 1;
    localparam int CNT_W  = $clog2(QUO_W);

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd4096;

    localparam logic [63:0] TURN32_HALF_RAD = 64'd341782638;
    localparam logic [63:0] TURN32_2P5_RAD  = 64'd1708913189;
    localparam logic [63:0] TURN32_4P5_RAD  = 64'd3076043740;
    localparam logic [63:0] TWO_PI_Q30      = 64'd6746518852;
    localparam logic [63:0] Q30_ONE         = 64'd1 << 30;

    localparam logic [63:0] OFF_R_FULL =
        (TURN32_HALF_RAD + (64'd1 << (31 - PHASE_BITS))) >> (32 - PHASE_BITS);
    localparam logic [63:0] OFF_G_FULL =
        (TURN32_2P5_RAD + (64'd1 << (31 - PHASE_BITS))) >> (32 - PHASE_BITS);
    localparam logic [63:0] OFF_B_FULL =
        (TURN32_4P5_RAD + (64'd1 << (31 - PHASE_BITS))) >> (32 - PHASE_BITS);

    localparam logic [PHASE_BITS-1:0] OFF_R = OFF_R_FULL[PHASE_BITS-1:0];
    localparam logic [PHASE_BITS-1:0] OFF_G = OFF_G_FULL[PHASE_BITS-1:0];
    localparam logic [PHASE_BITS-1:0] OFF_B = OFF_B_FULL[PHASE_BITS-1:0];

    localparam logic [63:0] TAYLOR_DIV [1:9] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306};

    typedef logic [PHASE_BITS-1:0] phase_t;
    typedef logic [V_W-1:0] chan_t;
    typedef logic [14:0] cos_tab_t [0:COS_QUARTER];

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic cos_tab_t build_cos_tab();
        cos_tab_t          tab;
        logic [63:0]       x;
        logic [63:0]       x2;
        logic [63:0]       term;
        logic signed [63:0] sum;
        logic [63:0]       rounded;
        for (int j = 0; j <= COS_QUARTER; j++)
        begin
            x = (64'(j) * TWO_PI_Q30 + (64'd1 << (COS_TABLE_BITS - 1))) >> COS_TABLE_BITS;
            x2 = (x * x) >> 30;
            term = Q30_ONE;
            sum = $signed(Q30_ONE);
            for (int k = 1; k <= 9; k++)
            begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[k];
                if ((k % 2) == 1)
                begin
                    sum = sum - $signed(term);
                end
                else
                begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            rounded = ($unsigned(sum) + (64'd1 << 15)) >> 16;
            tab[j] = rounded[14:0];
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

>>> hw/rtl/rcwg_div.sv
`include "rainbow_color_wheel_generator_macros.svh"

module rcwg_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rcwg_pkg::NUM_W-1:0] num,
    input  logic [rcwg_pkg::DEN_W-1:0] den,
    output rcwg_pkg::div_status_t      status,
    output logic [rcwg_pkg::QUO_W-1:0] quo
);
    import rcwg_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [DSH_W-1:0] dsh_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             ge;

    assign ge = rem_reg >= NUM_W'(dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= {den, {(QUO_W - 1){1'b0}}};
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - NUM_W'(dsh_reg);
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quo         = quo_reg;

    `RCWG_ASSERT_NXT(a_div_done_after_last, busy_reg && (cnt_reg == '0) && !start, done_reg && !busy_reg, "divider did not finish after its last step")
    `RCWG_ASSERT_IMP(a_div_idle_when_done, done_reg, !busy_reg, "divider busy while reporting done")
    `RCWG_ASSERT_NXT(a_div_start_busy, start, busy_reg && !done_reg, "divider did not start")

endmodule

>>> hw/rtl/rainbow_color_wheel_generator.sv
// Channel   Signals                                Direction
// input     in_valid, in_ready, is_blank,          request in
//           start_of_message
// output    out_valid, out_ready, colored,         request out
//           red, green, blue
// config    cfg_we, cfg_wdata (phase_step)         write only
//
// A colored request runs three cosine lookups, one range step, and three passes of the
// shared 8-step restoring divider, each with a load and a done cycle.
// A blank request goes straight to the done state; one with zero channel spread skips the divider.
// Reset sets phase_step to 4096 and the phase accumulator to zero; no clearing pass.
// The result waits in an output register, so a new request is taken while it stalls.
`include "rainbow_color_wheel_generator_macros.svh"

module rainbow_color_wheel_generator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rcwg_pkg::STEP_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        is_blank,
    input  logic                        start_of_message,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        colored,
    output logic [7:0]                  red,
    output logic [7:0]                  green,
    output logic [7:0]                  blue
);
    import rcwg_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_LOOK     = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_DIV_LOAD = 3'd3;
    localparam logic [2:0] ST_DIV_WAIT = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    localparam logic [1:0] CH_R = 2'd0;
    localparam logic [1:0] CH_G = 2'd1;
    localparam logic [1:0] CH_B = 2'd2;

    localparam logic [COS_TABLE_BITS-2:0] QUARTER_ADDR = (COS_TABLE_BITS - 1)'(COS_QUARTER);
    localparam logic [15:0] Q14_ONE = 16'd16384;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        ch_reg, ch_next;
    logic [STEP_W-1:0] phase_step_reg;
    phase_t            phase_acc_reg, phase_acc_next;
    chan_t             v_reg [0:2];
    chan_t             vmin_reg;
    chan_t             s_reg;
    logic [7:0]        res_reg [0:2];
    logic              res_colored_reg;
    logic              out_valid_reg, out_valid_next;
    logic              out_colored_reg;
    logic [7:0]        out_red_reg, out_green_reg, out_blue_reg;

    logic              accept;
    logic              out_load;
    phase_t            step_ext;
    phase_t            base_phase;
    phase_t            chan_off;
    phase_t            p;
    logic [PHASE_BITS+COS_TABLE_BITS-1:0] p_wide;
    logic [COS_TABLE_BITS-1:0] idx;
    logic [1:0]        quadrant;
    logic [COS_TABLE_BITS-2:0] addr;
    logic [14:0]       mag;
    logic [15:0]       cplus;
    logic [V_W:0]      v_wide;
    chan_t             v_now;
    chan_t             vmin_now, vmax_now;
    chan_t             diff;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_start;
    div_status_t       div_status;
    logic [QUO_W-1:0]  div_quo;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign step_ext = PHASE_BITS'(phase_step_reg);
    assign base_phase = start_of_message ? '0 : phase_acc_reg;

    always_comb
    begin
        case (ch_reg)
            CH_R:    chan_off = OFF_R;
            CH_G:    chan_off = OFF_G;
            default: chan_off = OFF_B;
        endcase
    end

    assign p        = phase_acc_reg - chan_off;
    assign p_wide   = {p, {COS_TABLE_BITS{1'b0}}};
    assign idx      = p_wide[PHASE_BITS+COS_TABLE_BITS-1:PHASE_BITS];
    assign quadrant = idx[COS_TABLE_BITS-1:COS_TABLE_BITS-2];

    always_comb
    begin
        if ((quadrant == 2'd0) || (quadrant == 2'd2))
        begin
            addr = {1'b0, idx[COS_TABLE_BITS-3:0]};
        end
        else
        begin
            addr = QUARTER_ADDR - {1'b0, idx[COS_TABLE_BITS-3:0]};
        end
    end

    assign mag    = COS_TAB[addr];
    assign cplus  = ((quadrant == 2'd1) || (quadrant == 2'd2)) ?
                    Q14_ONE - {1'b0, mag} : Q14_ONE + {1'b0, mag};
    assign v_wide = {cplus, 7'b0} - {7'b0, cplus};
    assign v_now  = v_wide[V_W-1:0];

    always_comb
    begin
        vmin_now = (v_reg[0] < v_reg[1]) ? v_reg[0] : v_reg[1];
        if (v_reg[2] < vmin_now)
        begin
            vmin_now = v_reg[2];
        end
        vmax_now = (v_reg[0] > v_reg[1]) ? v_reg[0] : v_reg[1];
        if (v_reg[2] > vmax_now)
        begin
            vmax_now = v_reg[2];
        end
    end

    assign diff      = v_reg[ch_reg] - vmin_reg;
    assign div_num   = NUM_W'({diff, 9'b0}) - NUM_W'({diff, 1'b0}) + NUM_W'(s_reg);
    assign div_den   = {s_reg, 1'b0};
    assign div_start = (state_reg == ST_DIV_LOAD);

    rcwg_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .status (div_status),
        .quo    (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        phase_acc_next = phase_acc_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ch_next = CH_R;
                    if (is_blank)
                    begin
                        phase_acc_next = base_phase;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        phase_acc_next = base_phase + step_ext;
                        state_next     = ST_LOOK;
                    end
                end
            end
            ST_LOOK:
            begin
                if (ch_reg == CH_B)
                begin
                    state_next = ST_RANGE;
                end
                else
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            ST_RANGE:
            begin
                ch_next    = CH_R;
                state_next = (vmax_now == vmin_now) ? ST_DONE : ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    if (ch_reg == CH_B)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_DIV_LOAD;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ch_reg         <= CH_R;
            phase_step_reg <= STEP_RESET;
            phase_acc_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            phase_acc_reg <= phase_acc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                phase_step_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_colored_reg <= !is_blank;
            res_reg[0]      <= '0;
            res_reg[1]      <= '0;
            res_reg[2]      <= '0;
        end
        if (state_reg == ST_LOOK)
        begin
            v_reg[ch_reg] <= v_now;
        end
        if (state_reg == ST_RANGE)
        begin
            vmin_reg <= vmin_now;
            s_reg    <= vmax_now - vmin_now;
        end
        if ((state_reg == ST_DIV_WAIT) && div_status.done)
        begin
            res_reg[ch_reg] <= div_quo;
        end
        if (out_load)
        begin
            out_colored_reg <= res_colored_reg;
            out_red_reg     <= res_reg[0];
            out_green_reg   <= res_reg[1];
            out_blue_reg    <= res_reg[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign colored   = out_colored_reg;
    assign red       = out_red_reg;
    assign green     = out_green_reg;
    assign blue      = out_blue_reg;

    `RCWG_ASSERT_IMP(a_blank_is_black, out_valid_reg && !out_colored_reg, (out_red_reg == 8'd0) && (out_green_reg == 8'd0) && (out_blue_reg == 8'd0), "blank result carries a color")
    `RCWG_ASSERT_NXT(a_phase_advance, accept && !is_blank && !start_of_message, phase_acc_reg == phase_t'($past(phase_acc_reg) + $past(step_ext)), "phase did not advance by the step")
    `RCWG_ASSERT_NXT(a_blank_keeps_phase, accept && is_blank, (phase_acc_reg == '0) || (phase_acc_reg == $past(phase_acc_reg)), "blank request moved the phase")
    `RCWG_ASSERT_NXT(a_done_waits, (state_reg == ST_DONE) && out_valid_reg && !out_ready, (state_reg == ST_DONE) && out_valid_reg, "result dropped while output stalled")
    `RCWG_ASSERT_IMP(a_busy_only_in_wait, div_status.busy, state_reg == ST_DIV_WAIT, "divider busy outside its wait state")

endmodule

>>> verif/rcwg_color_checker.sv
`timescale 1ns / 1ps

module rcwg_color_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rcwg_pkg::STEP_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        is_blank,
    input  logic                        start_of_message,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        colored,
    input  logic [7:0]                  red,
    input  logic [7:0]                  green,
    input  logic [7:0]                  blue,
    output int                          mismatch_count,
    output int                          pending_results
);

    localparam int PB        = rcwg_pkg::PHASE_BITS;
    localparam int TABLE_N   = 1 << rcwg_pkg::COS_TABLE_BITS;
    localparam int QUARTER_N = TABLE_N / 4;

    localparam logic [63:0] RED_TURN32   = 64'd341782638;
    localparam logic [63:0] GREEN_TURN32 = 64'd1708913189;
    localparam logic [63:0] BLUE_TURN32  = 64'd3076043740;
    localparam logic [63:0] TWO_PI_Q30   = 64'd6746518852;

    typedef struct packed {
        logic       colored;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } token_color_t;

    token_color_t      expected_colors[$];
    rcwg_pkg::phase_t  phase_acc;
    logic [15:0]       phase_step;
    int                cos_quarter_tab [0:QUARTER_N];

    // Q14 cosine over the first quarter turn, from a Q30 Taylor series.
    function automatic int quarter_cosine(int j);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x = (64'(j) * TWO_PI_Q30 + 64'(TABLE_N / 2)) / 64'(TABLE_N);
        x2 = (x * x) >> 30;
        term = 64'd1 << 30;
        sum = $signed(64'd1 << 30);
        for (int k = 1; k <= 9; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if ((k % 2) == 1)
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        return int'(($unsigned(sum) + 64'd32768) >> 16);
    endfunction

    function automatic int table_cosine(int idx);
        int i;
        int r;
        i = idx & (TABLE_N - 1);
        r = i % QUARTER_N;
        case (i / QUARTER_N)
            0:       return cos_quarter_tab[r];
            1:       return -cos_quarter_tab[QUARTER_N - r];
            2:       return -cos_quarter_tab[r];
            default: return cos_quarter_tab[QUARTER_N - r];
        endcase
    endfunction

    function automatic rcwg_pkg::phase_t turn_to_phase(logic [63:0] turn32);
        logic [63:0] rounded;
        rounded = (turn32 + (64'd1 << (31 - PB))) >> (32 - PB);
        return rounded[PB-1:0];
    endfunction

    function automatic int channel_level(rcwg_pkg::phase_t phase, logic [63:0] turn32);
        rcwg_pkg::phase_t p;
        int               idx;
        p = phase - turn_to_phase(turn32);
        idx = int'((32'(p) << rcwg_pkg::COS_TABLE_BITS) >> PB);
        return 127 * (16384 + table_cosine(idx));
    endfunction

    function automatic logic [7:0] scale_level(int v, int vmin, int span);
        longint q;
        q = (longint'(510) * longint'(v - vmin) + longint'(span)) / (2 * longint'(span));
        if (q > 255)
        begin
            q = 255;
        end
        return 8'(q);
    endfunction

    function automatic token_color_t predict_token_color(logic blank, logic start);
        token_color_t c;
        int           r;
        int           g;
        int           b;
        int           lo;
        int           hi;
        c = '0;
        if (start)
        begin
            phase_acc = '0;
        end
        if (blank)
        begin
            return c;
        end
        phase_acc = phase_acc + rcwg_pkg::phase_t'(phase_step);
        r = channel_level(phase_acc, RED_TURN32);
        g = channel_level(phase_acc, GREEN_TURN32);
        b = channel_level(phase_acc, BLUE_TURN32);
        lo = (r < g) ? r : g;
        lo = (b < lo) ? b : lo;
        hi = (r > g) ? r : g;
        hi = (b > hi) ? b : hi;
        c.colored = 1'b1;
        if (hi != lo)
        begin
            c.red   = scale_level(r, lo, hi - lo);
            c.green = scale_level(g, lo, hi - lo);
            c.blue  = scale_level(b, lo, hi - lo);
        end
        return c;
    endfunction

    initial
    begin
        for (int j = 0; j <= QUARTER_N; j++)
        begin
            cos_quarter_tab[j] = quarter_cosine(j);
        end
    end

    // Results are checked before new requests are queued so that a request and a
    // result on the same edge never pair up with each other.
    always @(posedge clk or negedge rst_n)
    begin : watch
        token_color_t want;
        token_color_t got;
        if (!rst_n)
        begin
            phase_acc = '0;
            phase_step = rcwg_pkg::STEP_RESET;
            expected_colors.delete();
            mismatch_count = 0;
            pending_results = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                phase_step = cfg_wdata;
            end
            if (out_valid && out_ready)
            begin
                got = {colored, red, green, blue};
                if (expected_colors.size() == 0)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("unexpected result: colored=%0d rgb=%0d,%0d,%0d",
                                 got.colored, got.red, got.green, got.blue);
                    end
                    mismatch_count++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (got.colored !== want.colored || got.red !== want.red ||
                        got.green !== want.green || got.blue !== want.blue)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("mismatch: expected colored=%0d rgb=%0d,%0d,%0d, got colored=%0d rgb=%0d,%0d,%0d",
                                     want.colored, want.red, want.green, want.blue,
                                     got.colored, got.red, got.green, got.blue);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_colors.push_back(predict_token_color(is_blank, start_of_message));
            end
            pending_results = expected_colors.size();
        end
    end

endmodule

>>> verif/tb_rainbow_color_wheel_generator.sv
`timescale 1ns / 1ps

module tb_rainbow_color_wheel_generator;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_REQUESTS = 163;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [rcwg_pkg::STEP_W-1:0] cfg_wdata;
    logic                        in_valid;
    logic                        in_ready;
    logic                        is_blank;
    logic                        start_of_message;
    logic                        out_valid;
    logic                        out_ready;
    logic                        colored;
    logic [7:0]                  red;
    logic [7:0]                  green;
    logic [7:0]                  blue;

    int   mismatch_count;
    int   pending_results;
    int   cycle_count;
    logic fast_mode;
    bit   holdoff_req;

    rainbow_color_wheel_generator i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .is_blank         (is_blank),
        .start_of_message (start_of_message),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .colored          (colored),
        .red              (red),
        .green            (green),
        .blue             (blue)
    );

    rcwg_color_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .is_blank         (is_blank),
        .start_of_message (start_of_message),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .colored          (colored),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .mismatch_count   (mismatch_count),
        .pending_results  (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("rainbow_color_wheel_generator test failed");
        $finish;
    end

    task automatic send_token(input logic blank, input logic start);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        is_blank <= blank;
        start_of_message <= start;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_step(input logic [rcwg_pkg::STEP_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int                          gap;
        bit                          held;
        out_ready <= 1'b0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holdoff_req && !held)
            begin
                gap = HOLD_CYCLES;
                held = 1'b1;
            end
            else if (fast_mode)
            begin
                gap = 0;
            end
            else
            begin
                gap = $urandom_range(0, 19);
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        int                          remaining;
        int                          msg_len;
        logic [rcwg_pkg::STEP_W-1:0] step;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        in_valid <= 1'b0;
        is_blank <= 1'b0;
        start_of_message <= 1'b0;
        fast_mode = 1'b0;
        holdoff_req = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The step from reset, then a step of zero, the largest step, and half a turn.
        send_token(1'b0, 1'b1);
        send_token(1'b0, 1'b0);
        send_token(1'b0, 1'b0);
        send_token(1'b1, 1'b0);
        send_token(1'b1, 1'b1);
        send_token(1'b0, 1'b0);
        send_token(1'b1, 1'b0);
        send_token(1'b0, 1'b0);
        drain_results();
        write_step('0);
        send_token(1'b0, 1'b1);
        send_token(1'b0, 1'b0);
        send_token(1'b1, 1'b1);
        send_token(1'b0, 1'b0);
        drain_results();
        write_step('1);
        send_token(1'b0, 1'b1);
        send_token(1'b0, 1'b0);
        send_token(1'b0, 1'b0);
        send_token(1'b0, 1'b0);
        drain_results();
        write_step(16'h8000);
        send_token(1'b0, 1'b0);
        send_token(1'b0, 1'b0);
        send_token(1'b0, 1'b1);
        send_token(1'b0, 1'b0);
        drain_results();

        for (int phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++)
        begin
            case (phase_idx)
                0:       step = 16'd1;
                1:       step = '1;
                2:       step = '0;
                3:       step = rcwg_pkg::STEP_RESET;
                default: step = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(1, 3000));
            endcase
            write_step(step);
            fast_mode = (phase_idx == 1) || ($urandom_range(0, 4) == 0);
            remaining = PHASE_REQUESTS;
            while (remaining > 0)
            begin
                msg_len = $urandom_range(1, 30);
                for (int i = 0; i < msg_len && remaining > 0; i++)
                begin
                    if (phase_idx == 3 && remaining == 80)
                    begin
                        holdoff_req = 1'b1;
                    end
                    if (phase_idx == 5 && remaining == 80)
                    begin
                        drain_results();
                    end
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_token(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    end
                    else
                    begin
                        send_token($urandom_range(0, 4) == 0, i == 0);
                    end
                    remaining--;
                end
            end
            fast_mode = 1'b0;
            drain_results();
        end

        if (mismatch_count == 0 && pending_results == 0)
        begin
            $display("rainbow_color_wheel_generator test passed");
        end
        else
        begin
            $display("rainbow_color_wheel_generator test failed");
        end
        $finish;
    end

endmodule
